// File: rtl/core/ple_pkg.sv
`default_nettype none

package ple_pkg;

   // Command codes.
   localparam logic [2:0] CMD_ADD_FRONT = 3'd0;
   localparam logic [2:0] CMD_ADD_REAR  = 3'd1;
   localparam logic [2:0] CMD_REM_FRONT = 3'd2;
   localparam logic [2:0] CMD_REM_REAR  = 3'd3;
   localparam logic [2:0] CMD_INS_AT    = 3'd4;
   localparam logic [2:0] CMD_REM_AT    = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [6:0]  position;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [6:0]  count_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0] status;
      logic       insert;
      logic       remove;
   } decode_type;

endpackage

`default_nettype wire

// File: rtl/core/ple_decode.sv
`default_nettype none

module ple_decode #(
   parameter int CAPACITY = 64
) (
   input  wire logic [2:0]                        cmd,
   input  wire logic [6:0]                        position,
   input  wire logic [$clog2(CAPACITY+1)-1:0]     count,
   output ple_pkg::decode_type                    ctl,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] slot,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] stop
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW + 1 : 8;

   logic [PW-1:0] pos_x;
   logic [PW-1:0] cnt_x;
   logic          full;
   logic          empty;

   assign pos_x = PW'(position);
   assign cnt_x = PW'(count);
   assign full  = (count == CW'(CAPACITY));
   assign empty = (count == '0);

   always_comb begin
      ctl.status = ple_pkg::ST_OK;
      ctl.insert = 1'b0;
      ctl.remove = 1'b0;
      slot       = '0;
      case (cmd)
         ple_pkg::CMD_ADD_FRONT: begin
            if (full) begin
               ctl.status = ple_pkg::ST_FULL;
            end else begin
               ctl.insert = 1'b1;
            end
         end
         ple_pkg::CMD_ADD_REAR: begin
            if (full) begin
               ctl.status = ple_pkg::ST_FULL;
            end else begin
               ctl.insert = 1'b1;
               slot       = AW'(cnt_x);
            end
         end
         ple_pkg::CMD_REM_FRONT: begin
            if (empty) begin
               ctl.status = ple_pkg::ST_UNDER;
            end else begin
               ctl.remove = 1'b1;
            end
         end
         ple_pkg::CMD_REM_REAR: begin
            if (empty) begin
               ctl.status = ple_pkg::ST_UNDER;
            end else begin
               ctl.remove = 1'b1;
               slot       = AW'(cnt_x - PW'(1));
            end
         end
         ple_pkg::CMD_INS_AT: begin
            if (pos_x == '0) begin
               ctl.status = ple_pkg::ST_UNDER;
            end else if (pos_x > cnt_x + PW'(1)) begin
               ctl.status = ple_pkg::ST_RANGE;
            end else if (full) begin
               ctl.status = ple_pkg::ST_FULL;
            end else begin
               ctl.insert = 1'b1;
               slot       = AW'(pos_x - PW'(1));
            end
         end
         ple_pkg::CMD_REM_AT: begin
            if (pos_x > cnt_x) begin
               ctl.status = ple_pkg::ST_RANGE;
            end else if (pos_x == '0) begin
               ctl.status = ple_pkg::ST_UNDER;
            end else begin
               ctl.remove = 1'b1;
               slot       = AW'(pos_x - PW'(1));
            end
         end
         default: begin
            ctl.status = ple_pkg::ST_OK;
         end
      endcase
   end

   // An insert shifts down to its slot; a remove shifts up to the last element.
   assign stop = ctl.remove ? AW'(cnt_x - PW'(1)) : slot;

endmodule

`default_nettype wire

// File: rtl/core/positional_list_engine.sv
// An insert at slot p moves each element from the rear down to p back by one slot and then writes
// the new value at p; a remove first reads the element at p, then moves the elements behind it forward by one.
// Each moved element costs a store read and a store write through the one store port pair.
// The result strobe comes in the first idle cycle, when the next start may be taken.
// Reset (synchronous) clears the count and the sequencer; store contents stay undefined.
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ple_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output ple_pkg::rsp_type      rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TAKE = 3'd1;
   localparam logic [2:0] S_CAP  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         stop_ff, stop_in;
   logic                  ins_ff, ins_in;
   logic                  rem_ff, rem_in;
   logic [1:0]            status_ff, status_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [ELEM_WIDTH-1:0] rdata_ff;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   ple_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic [ELEM_WIDTH-1:0] mem [CAPACITY];

   ple_pkg::decode_type   ctl;
   logic [AW-1:0]         slot;
   logic [AW-1:0]         stop;
   logic [AW-1:0]         step;
   logic                  accept;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic [VW-1:0]         vin_x;
   logic [VW-1:0]         vout_x;

   ple_decode #(
      .CAPACITY(CAPACITY)
   ) u_decode (
      .cmd      (req_data.cmd),
      .position (req_data.position),
      .count    (count_ff),
      .ctl      (ctl),
      .slot     (slot),
      .stop     (stop)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // The one address unit: inserts walk toward the front, removes toward the rear.
   assign step = rem_ff ? (idx_ff + AW'(1)) : (idx_ff - AW'(1));

   assign rd_en   = (state_ff == S_TAKE) || (state_ff == S_RD);
   assign rd_addr = (state_ff == S_TAKE) ? idx_ff : step;
   assign wr_en   = (state_ff == S_WR) || ((state_ff == S_FIN) && ins_ff);
   assign wr_data = (state_ff == S_WR) ? rdata_ff : val_ff;

   assign vin_x  = VW'(req_data.value_in);
   assign vout_x = VW'(val_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      ins_in        = ins_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ins_in    = ctl.insert;
               rem_in    = ctl.remove;
               status_in = ctl.status;
               stop_in   = stop;
               val_in    = ELEM_WIDTH'(vin_x);
               if (ctl.insert) begin
                  idx_in   = AW'(count_ff);
                  state_in = (AW'(count_ff) == stop) ? S_FIN : S_RD;
               end else if (ctl.remove) begin
                  idx_in   = slot;
                  state_in = S_TAKE;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_TAKE: begin
            state_in = S_CAP;
         end
         S_CAP: begin
            val_in   = rdata_ff;
            state_in = (idx_ff == stop_ff) ? S_FIN : S_RD;
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            idx_in   = step;
            state_in = (step == stop_ff) ? S_FIN : S_RD;
         end
         S_FIN: begin
            if (ins_ff) begin
               count_in = count_ff + CW'(1);
            end else if (rem_ff) begin
               count_in = count_ff - CW'(1);
            end
            rsp_strobe_in         = 1'b1;
            rsp_data_in.status    = status_ff;
            rsp_data_in.value_out = rem_ff ? vout_x[31:0] : 32'd0;
            rsp_data_in.count_out = 7'(count_in);
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      stop_ff     <= stop_in;
      ins_ff      <= ins_in;
      rem_ff      <= rem_in;
      status_ff   <= status_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/ple_checker.sv
`default_nettype none

module ple_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire ple_pkg::req_type req_data,
   input wire logic             rsp_strobe,
   input wire ple_pkg::rsp_type rsp_data
);

   // Every accepted transaction raises busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result is only shown once the block has gone idle again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Results are single-cycle pulses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A failed command never returns an element.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ple_pkg::ST_OK)) |-> (rsp_data.value_out == 32'd0))
      else $error("error result carries a nonzero value");

   // A full status never comes with an empty list.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == ple_pkg::ST_FULL)) |-> (rsp_data.count_out != 7'd0)
         || (rsp_data.status != ple_pkg::ST_FULL))
      else $error("full status reported with an empty list");

endmodule

bind positional_list_engine ple_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
